// File: rtl/nnr_pkg.sv
// ----------------------------------------------------------------------------
// nnr_pkg: shared types and constants
// Field widths, request and register codes, payload structs for the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned USED_W  = 9;
  localparam int unsigned PROD_W  = STEP_W + COORD_W;
  // product + sign-extended offset + half, no overflow
  localparam int unsigned SUM_W   = PROD_W + 2;

  localparam logic signed [PIX_W-1:0] FILL_VALUE = 16'sh8000;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
  localparam logic [USED_W-1:0] USED_RESET = 9'd256;

  typedef enum logic [2:0] {
    REG_STEP       = 3'd0,
    REG_COL_OFS    = 3'd1,
    REG_LINE_OFS   = 3'd2,
    REG_COLS_USED  = 3'd3,
    REG_LINES_USED = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                    req_type;
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      line;
    logic signed [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_out;
    logic                    out_of_range;
  } out_item_t;

  // per-axis mapper control
  typedef struct packed {
    logic load;     // item in the first stage is a load
    logic adv_mul;  // product stage takes a new item
    logic adv_cmp;  // compare stage takes a new item
  } map_ctl_t;

endpackage

`default_nettype wire

// File: rtl/nearest_neighbor_image_resampler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resampler: nearest-neighbor image scaler
// Loads source pixels into an on-chip store and returns resampled pixels.
// ----------------------------------------------------------------------------
// Every accepted transaction returns exactly one result, in order. A load
// (req_type 0) writes pixel_in at (line, col) if both lie inside the active
// source size and echoes pixel_in; out_of_range flags a dropped write. A
// fetch (req_type 1) maps each output coordinate with
// floor(step_ratio*coord + offset + 0.5) in fixed point (FRAC_BITS fraction
// bits) and returns the stored pixel, or -32768 with out_of_range set when
// either index is negative or at/above its active limit (the smaller of the
// used count and SRC_COLS / SRC_LINES). Throughput is one transaction per
// clock while the output is not stalled; a result passes in order through the
// input register, the multiply stage, the add/compare stage and the registered
// read of the image RAM. All RAM traffic (writes and reads) happens in one
// pipeline stage in transaction order, so a fetch always sees every earlier
// load without forwarding. Each stage holds its item only while the stage
// after it is full and stalled, so bubbles are squeezed out and new input is
// taken while a result waits at the output. Fetching a pixel that was never
// loaded since reset returns an undefined value. The store is not cleared at
// reset, so the block is ready right away. Configure only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_resampler #(
  parameter int unsigned SRC_COLS  = 256,
  parameter int unsigned SRC_LINES = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input transactions
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire nnr_pkg::in_item_t  in_data_i,
  // result transactions
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output nnr_pkg::out_item_t      out_data_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  import nnr_pkg::*;

  localparam int unsigned DEPTH = SRC_COLS * SRC_LINES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CIW   = $clog2(SRC_COLS);
  localparam int unsigned LIW   = $clog2(SRC_LINES);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]       step_q, step_d;
  logic signed [OFS_W-1:0] col_ofs_q, col_ofs_d;
  logic signed [OFS_W-1:0] line_ofs_q, line_ofs_d;
  logic [USED_W-1:0]       cols_used_q, cols_used_d;
  logic [USED_W-1:0]       lines_used_q, lines_used_d;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_comb begin
    step_d       = step_q;
    col_ofs_d    = col_ofs_q;
    line_ofs_d   = line_ofs_q;
    cols_used_d  = cols_used_q;
    lines_used_d = lines_used_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP:       step_d       = pwdata[STEP_W-1:0];
        REG_COL_OFS:    col_ofs_d    = $signed(pwdata);
        REG_LINE_OFS:   line_ofs_d   = $signed(pwdata);
        REG_COLS_USED:  cols_used_d  = pwdata[USED_W-1:0];
        REG_LINES_USED: lines_used_d = pwdata[USED_W-1:0];
        default: ;  // unmapped address: write ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= STEP_RESET;
      col_ofs_q    <= '0;
      line_ofs_q   <= '0;
      cols_used_q  <= USED_RESET;
      lines_used_q <= USED_RESET;
    end else begin
      step_q       <= step_d;
      col_ofs_q    <= col_ofs_d;
      line_ofs_q   <= line_ofs_d;
      cols_used_q  <= cols_used_d;
      lines_used_q <= lines_used_d;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP:       prdata = {{(32-STEP_W){1'b0}}, step_q};
      REG_COL_OFS:    prdata = col_ofs_q;
      REG_LINE_OFS:   prdata = line_ofs_q;
      REG_COLS_USED:  prdata = {{(32-USED_W){1'b0}}, cols_used_q};
      REG_LINES_USED: prdata = {{(32-USED_W){1'b0}}, lines_used_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d, v4_q, v4_d;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o = !adv1;

  assign v1_d = adv1 ? in_valid_i : v1_q;
  assign v2_d = adv2 ? v1_q : v2_q;
  assign v3_d = adv3 ? v2_q : v3_q;
  assign v4_d = adv4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Payload stages
  // --------------------------------------------------------------------------
  in_item_t                item1_q;
  logic signed [PIX_W-1:0] pix2_q, pix3_q, pix4_q;
  logic                    load2_q, load3_q, load4_q;
  logic                    oor4_q, oor4_d;
  logic                    load1;

  assign load1 = (item1_q.req_type == REQ_LOAD);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      item1_q <= in_data_i;
    end
    if (adv2) begin
      pix2_q  <= item1_q.pixel_in;
      load2_q <= load1;
    end
    if (adv3) begin
      pix3_q  <= pix2_q;
      load3_q <= load2_q;
    end
    if (adv4) begin
      pix4_q  <= pix3_q;
      load4_q <= load3_q;
      oor4_q  <= oor4_d;
    end
  end

  // --------------------------------------------------------------------------
  // Index mapping, one unit per axis (stages 2 and 3)
  // --------------------------------------------------------------------------
  map_ctl_t       map_ctl;
  logic [CIW-1:0] col_idx;
  logic [LIW-1:0] line_idx;
  logic           col_oor, line_oor;

  assign map_ctl = '{load: load1, adv_mul: adv2, adv_cmp: adv3};

  nnr_map #(
    .SIZE      (SRC_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_map_col (
    .clk_i    (clk_i),
    .ctl_i    (map_ctl),
    .coord_i  (item1_q.col),
    .step_i   (step_q),
    .offset_i (col_ofs_q),
    .used_i   (cols_used_q),
    .idx_o    (col_idx),
    .oor_o    (col_oor)
  );

  nnr_map #(
    .SIZE      (SRC_LINES),
    .FRAC_BITS (FRAC_BITS)
  ) u_map_line (
    .clk_i    (clk_i),
    .ctl_i    (map_ctl),
    .coord_i  (item1_q.line),
    .step_i   (step_q),
    .offset_i (line_ofs_q),
    .used_i   (lines_used_q),
    .idx_o    (line_idx),
    .oor_o    (line_oor)
  );

  // --------------------------------------------------------------------------
  // Image store access (stage 3 -> 4), strictly in transaction order
  // --------------------------------------------------------------------------
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [PIX_W-1:0]    ram_rdata;

  assign oor4_d   = col_oor || line_oor;
  assign ram_addr = AW'(line_idx) * AW'(SRC_COLS) + AW'(col_idx);
  assign ram_we   = adv4 && v3_q && load3_q && !oor4_d;
  assign ram_re   = adv4 && v3_q && !load3_q && !oor4_d;

  nnr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk_i   (clk_i),
    .en_i    (ram_we || ram_re),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pix3_q),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result: loads echo their pixel, fetches return RAM data or fill
  // --------------------------------------------------------------------------
  assign out_valid_o = v4_q;

  always_comb begin
    if (load4_q) begin
      out_data_o.pixel_out = pix4_q;
    end else if (oor4_q) begin
      out_data_o.pixel_out = FILL_VALUE;
    end else begin
      out_data_o.pixel_out = $signed(ram_rdata);
    end
    out_data_o.out_of_range = oor4_q;
  end

`ifndef SYNTHESIS
  // single-port store: never read and write in one cycle
  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("image store read and written in the same cycle");

  // the store is touched only for an in-range item leaving stage 3
  a_ram_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we || ram_re) |-> (v3_q && !col_oor && !line_oor))
    else $error("image store accessed by an invalid or out-of-range item");

  // a read always lands in a valid output stage
  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (out_valid_o && !load4_q && !oor4_q))
    else $error("read data does not reach a fetch result");

  // input is only held off when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a pipeline bubble");
`endif

endmodule

`default_nettype wire

// File: rtl/nnr_ram.sv
// ----------------------------------------------------------------------------
// nnr_ram: generic single-port RAM
// One access per cycle, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/nnr_map.sv
// ----------------------------------------------------------------------------
// nnr_map: coordinate to source index mapper, one axis
// Stage 1 multiplies step by coordinate; stage 2 adds offset and half,
// floors and checks against the active size (a load passes its coordinate through and checks it).
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_map #(
  parameter int unsigned SIZE      = 256,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned IW       = $clog2(SIZE)
) (
  input  wire logic                          clk_i,
  input  wire nnr_pkg::map_ctl_t             ctl_i,
  input  wire logic [nnr_pkg::COORD_W-1:0]   coord_i,
  input  wire logic [nnr_pkg::STEP_W-1:0]    step_i,
  input  wire logic signed [nnr_pkg::OFS_W-1:0] offset_i,
  input  wire logic [nnr_pkg::USED_W-1:0]    used_i,
  output logic      [IW-1:0]                 idx_o,
  output logic                               oor_o
);

  import nnr_pkg::*;

  localparam int unsigned SW = $clog2(SIZE + 1);
  localparam int unsigned LW = (USED_W > SW) ? USED_W : SW;
  localparam int unsigned QW = SUM_W - 1 - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [LW-1:0]    SIZE_L = LW'(SIZE);

  // product stage
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [COORD_W-1:0] coord_q;
  logic               load_q;

  // compare stage
  logic [IW-1:0] idx_q, idx_d;
  logic          oor_q, oor_d;

  logic [LW-1:0]           lim;
  logic signed [SUM_W-1:0] sum;
  logic [QW-1:0]           q;

  assign prod_d = PROD_W'(step_i) * PROD_W'(coord_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_mul) begin
      prod_q  <= prod_d;
      coord_q <= coord_i;
      load_q  <= ctl_i.load;
    end
  end

  always_comb begin
    lim = (LW'(used_i) < SIZE_L) ? LW'(used_i) : SIZE_L;
    sum = $signed({{(SUM_W-PROD_W){1'b0}}, prod_q})
        + $signed({{(SUM_W-OFS_W){offset_i[OFS_W-1]}}, offset_i})
        + $signed(HALF);
    q   = sum[SUM_W-2:FRAC_BITS];
    if (load_q) begin
      idx_d = coord_q[IW-1:0];
      oor_d = !(coord_q < COORD_W'(lim));
    end else begin
      idx_d = q[IW-1:0];
      oor_d = sum[SUM_W-1] || !(q < QW'(lim));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_cmp) begin
      idx_q <= idx_d;
      oor_q <= oor_d;
    end
  end

  assign idx_o = idx_q;
  assign oor_o = oor_q;

endmodule

`default_nettype wire

// File: test/nearest_neighbor_image_resampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resampler_tb: self-checking bench for the resampler
// Drives load and fetch transactions with random idle gaps and output stalls.
// It predicts every result from its own fixed-point mapping and its own copy
// of the source image, and checks register reset values and read-back.
// ----------------------------------------------------------------------------

module nearest_neighbor_image_resampler_tb;
  import nnr_pkg::*;

  localparam int unsigned SRC_COLS  = 256;
  localparam int unsigned SRC_LINES = 256;
  localparam int unsigned FRAC_BITS = 16;
  // accept-to-result latency of the block
  localparam int unsigned PIPE_LAT  = 3;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RAND_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 80;

  // --------------------------------------------------------------------------
  // DUT signals, inputs all known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  nearest_neighbor_image_resampler #(
    .SRC_COLS (SRC_COLS),
    .SRC_LINES(SRC_LINES),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench-side copy of the block: configuration and source image
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0]        cfg_step;
  logic signed [OFS_W-1:0]  cfg_col_ofs;
  logic signed [OFS_W-1:0]  cfg_line_ofs;
  logic [USED_W-1:0]        cfg_cols_used;
  logic [USED_W-1:0]        cfg_lines_used;

  // pixel store indexed by {line, col}; written marks entries loaded since reset
  logic signed [PIX_W-1:0]  src_pix     [0:SRC_LINES*SRC_COLS-1];
  bit                       src_written [0:SRC_LINES*SRC_COLS-1];

  out_item_t exp_pixels[$];   // expected results, oldest first

  bit calm = 1'b0;            // no idling on either side when set
  int unsigned err_cnt      = 0;
  int unsigned n_loads      = 0;
  int unsigned n_fetches    = 0;
  int unsigned n_oor        = 0;
  int unsigned n_checked    = 0;
  int unsigned n_reg_writes = 0;
  int unsigned idle_cycles  = 0;

  function automatic int unsigned active_limit(input logic [USED_W-1:0] used,
                                               input int unsigned size);
    return (32'(used) < size) ? 32'(used) : size;
  endfunction

  // floor(step*coord + ofs + half) in Q.FRAC_BITS, 64-bit so nothing wraps.
  // Returns 1 with the index when it lies in [0, lim).
  function automatic bit map_coord(input logic [COORD_W-1:0] coord,
                                   input logic signed [OFS_W-1:0] ofs,
                                   input int unsigned lim,
                                   output logic [7:0] idx);
    logic [PROD_W-1:0]  prod;
    logic signed [63:0] acc;
    logic [63:0]        q;
    prod = PROD_W'(cfg_step) * PROD_W'(coord);
    acc  = 64'(ofs);   // sign-extends
    acc  = acc + $signed({24'd0, prod}) + (64'sd1 <<< (FRAC_BITS - 1));
    idx  = '0;
    if (acc < 0) begin
      return 1'b0;
    end
    q = acc >>> FRAC_BITS;
    if (q >= 64'(lim)) begin
      return 1'b0;
    end
    idx = q[7:0];
    return 1'b1;
  endfunction

  // Expected result of one accepted transaction; applies loads to the store.
  function automatic out_item_t resample_model(input in_item_t item);
    out_item_t   res;
    int unsigned clim;
    int unsigned llim;
    logic [7:0]  ci;
    logic [7:0]  li;
    bit          col_ok;
    bit          line_ok;
    clim = active_limit(cfg_cols_used, SRC_COLS);
    llim = active_limit(cfg_lines_used, SRC_LINES);
    if (item.req_type == REQ_LOAD) begin
      col_ok  = 32'(item.col) < clim;
      line_ok = 32'(item.line) < llim;
      if (col_ok && line_ok) begin
        src_pix[{item.line[7:0], item.col[7:0]}]     = item.pixel_in;
        src_written[{item.line[7:0], item.col[7:0]}] = 1'b1;
      end
      res.pixel_out = item.pixel_in;   // loads always echo
      n_loads++;
    end else begin
      col_ok  = map_coord(item.col, cfg_col_ofs, clim, ci);
      line_ok = map_coord(item.line, cfg_line_ofs, llim, li);
      res.pixel_out = (col_ok && line_ok) ? src_pix[{li, ci}] : FILL_VALUE;
      n_fetches++;
    end
    res.out_of_range = !(col_ok && line_ok);
    if (res.out_of_range) begin
      n_oor++;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction, optional idle gap before it.
  // Valid stays high on return so back-to-back transactions need no toggle;
  // anything that waits without sending lowers it first.
  // --------------------------------------------------------------------------
  task automatic push_item(input in_item_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    exp_pixels.push_back(resample_model(item));
  endtask

  // A fetch that would land on a never-loaded entry gets that entry loaded
  // first, so reads of undefined store content never happen.
  task automatic send_req(input in_item_t item);
    logic [7:0] ci;
    logic [7:0] li;
    bit         col_ok;
    bit         line_ok;
    in_item_t   fill;
    if (item.req_type == REQ_FETCH) begin
      col_ok  = map_coord(item.col, cfg_col_ofs,
                          active_limit(cfg_cols_used, SRC_COLS), ci);
      line_ok = map_coord(item.line, cfg_line_ofs,
                          active_limit(cfg_lines_used, SRC_LINES), li);
      if (col_ok && line_ok && !src_written[{li, ci}]) begin
        fill.req_type = REQ_LOAD;
        fill.col      = {8'd0, ci};
        fill.line     = {8'd0, li};
        fill.pixel_in = PIX_W'($urandom);
        push_item(fill);
      end
    end
    push_item(item);
  endtask

  function automatic in_item_t make_item(input logic req, input int unsigned col,
                                         input int unsigned line, input int unsigned pix);
    in_item_t it;
    it.req_type = req;
    it.col      = col[COORD_W-1:0];
    it.line     = line[COORD_W-1:0];
    it.pixel_in = pix[PIX_W-1:0];
    return it;
  endfunction

  // Lower valid, wait for every expected result, then let the pipe settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (exp_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: setup then access; transfer at the access-phase edge
  // --------------------------------------------------------------------------
  task automatic apb_access(input reg_idx_e idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [31:0] want);
    logic [31:0] got;
    apb_access(idx, 1'b0, '0, got);
    if (got !== want) begin
      $error("register %s: expected 0x%08h, got 0x%08h", idx.name(), want, got);
      err_cnt++;
    end
  endtask

  // Write, mirror into the predictor, read back the register's width.
  task automatic set_reg(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] unused;
    logic [31:0] want;
    apb_access(idx, 1'b1, val, unused);
    n_reg_writes++;
    case (idx)
      REG_STEP: begin
        cfg_step = val[STEP_W-1:0];
        want     = {8'd0, val[STEP_W-1:0]};
      end
      REG_COL_OFS: begin
        cfg_col_ofs = val;
        want        = val;
      end
      REG_LINE_OFS: begin
        cfg_line_ofs = val;
        want         = val;
      end
      REG_COLS_USED: begin
        cfg_cols_used = val[USED_W-1:0];
        want          = {23'd0, val[USED_W-1:0]};
      end
      default: begin
        cfg_lines_used = val[USED_W-1:0];
        want           = {23'd0, val[USED_W-1:0]};
      end
    endcase
    check_reg(idx, want);
  endtask

  task automatic configure(input logic [31:0] step, input logic [31:0] cofs,
                           input logic [31:0] lofs, input logic [31:0] cols,
                           input logic [31:0] lines);
    wait_idle();
    set_reg(REG_STEP, step);
    set_reg(REG_COL_OFS, cofs);
    set_reg(REG_LINE_OFS, lofs);
    set_reg(REG_COLS_USED, cols);
    set_reg(REG_LINES_USED, lines);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, none once calm is set
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && rst_ni && $urandom_range(0, 6) == 0) begin
      stall_left  <= $urandom_range(0, 12);   // stalls still to follow this one
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d, out_of_range %0b",
               out_data_o.pixel_out, out_data_o.out_of_range);
        err_cnt++;
      end else begin
        want = exp_pixels.pop_front();
        n_checked++;
        if (out_data_o.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel_out, out_data_o.pixel_out);
          err_cnt++;
        end
        if (out_data_o.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                 out_data_o.out_of_range);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_reg(REG_STEP, {8'd0, STEP_RESET});
    check_reg(REG_COL_OFS, 32'd0);
    check_reg(REG_LINE_OFS, 32'd0);
    check_reg(REG_COLS_USED, {23'd0, USED_RESET});
    check_reg(REG_LINES_USED, {23'd0, USED_RESET});
  endtask

  task automatic test_directed_cases();
    // identity mapping at reset: corners, extremes of pixel, loads off the edge
    send_req(make_item(REQ_LOAD, 0, 0, 16'h8000));
    send_req(make_item(REQ_LOAD, 255, 255, 16'h7FFF));
    send_req(make_item(REQ_LOAD, 1, 0, 16'h5A5A));
    send_req(make_item(REQ_LOAD, 256, 0, 16'h1234));      // col just past limit
    send_req(make_item(REQ_LOAD, 0, 256, 16'hA5A5));      // line just past limit
    send_req(make_item(REQ_LOAD, 65535, 65535, 16'hFFFF));
    send_req(make_item(REQ_FETCH, 0, 0, 16'hFFFF));       // pixel_in ignored
    send_req(make_item(REQ_FETCH, 255, 255, 0));
    send_req(make_item(REQ_FETCH, 256, 0, 0));
    send_req(make_item(REQ_FETCH, 65535, 65535, 16'hFFFF));
    // zero step: rounding of exactly one half goes up, just below goes down
    configure(32'd0, 32'h0000_8000, 32'h0000_7FFF, 256, 256);
    send_req(make_item(REQ_FETCH, 65535, 12345, 0));      // maps to col 1, line 0
    // offset -0.5 rounds to zero, one LSB further is negative
    configure(32'd0, 32'hFFFF_8000, 32'hFFFF_7FFF, 256, 256);
    send_req(make_item(REQ_FETCH, 7, 7, 0));
    // largest step and offsets: no intermediate may wrap
    configure(32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 256, 256);
    send_req(make_item(REQ_FETCH, 0, 0, 0));
    send_req(make_item(REQ_FETCH, 65535, 65535, 0));
    configure(32'h00FF_FFFF, 32'h8000_0000, 32'h8000_0000, 256, 256);
    send_req(make_item(REQ_FETCH, 65535, 65535, 0));      // huge product, min offset
    // zero used count: everything out of range, load writes nothing
    configure(32'h0001_0000, 32'd0, 32'd0, 0, 0);
    send_req(make_item(REQ_LOAD, 0, 0, 16'h0F0F));
    send_req(make_item(REQ_FETCH, 0, 0, 0));
    // single-pixel source
    configure(32'h0001_0000, 32'd0, 32'd0, 1, 1);
    send_req(make_item(REQ_LOAD, 0, 0, 16'h0001));
    send_req(make_item(REQ_LOAD, 1, 0, 16'h0002));
    send_req(make_item(REQ_FETCH, 0, 0, 0));
    send_req(make_item(REQ_FETCH, 0, 1, 0));
    // used counts above the store size clamp to the store size
    configure(32'h0001_0000, 32'd0, 32'd0, 511, 257);
    send_req(make_item(REQ_LOAD, 255, 255, 16'h4321));
    send_req(make_item(REQ_FETCH, 255, 255, 0));
    send_req(make_item(REQ_LOAD, 256, 255, 16'h1111));
  endtask

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h00FF_FFFF;
      2, 3:    return 32'h0001_0000;
      4:       return $urandom;
      default: return $urandom_range(8192, 196608);   // 1/8 .. 3 source px per output
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, 36 * 65536) - 4 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_used();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd256;
      2:       return $urandom_range(257, 511);
      3:       return 32'd1;
      default: return $urandom_range(2, 256);
    endcase
  endfunction

  // Mostly in-range loads and fetches near the image, the rest noise.
  task automatic test_random_traffic();
    in_item_t    item;
    int unsigned clim;
    int unsigned llim;
    int unsigned roll;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        configure(32'h0001_0000, 32'd0, 32'd0, 256, 256);
      end else begin
        configure(rand_step(), rand_offset(), rand_offset(), rand_used(), rand_used());
      end
      if (ph == RAND_PHASES - 1) begin
        calm = 1'b1;   // final phase runs flat out
      end
      clim = active_limit(cfg_cols_used, SRC_COLS);
      llim = active_limit(cfg_lines_used, SRC_LINES);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        item.pixel_in = PIX_W'($urandom);
        if (roll < 40 && clim != 0 && llim != 0) begin
          item.req_type = REQ_LOAD;
          item.col      = COORD_W'($urandom_range(0, clim - 1));
          item.line     = COORD_W'($urandom_range(0, llim - 1));
        end else if (roll < 85) begin
          item.req_type = REQ_FETCH;
          item.col      = COORD_W'($urandom_range(0, 300));
          item.line     = COORD_W'($urandom_range(0, 300));
        end else begin
          item.req_type = 1'($urandom);
          item.col      = COORD_W'($urandom);
          item.line     = COORD_W'($urandom);
        end
        send_req(item);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_step       = STEP_RESET;
    cfg_col_ofs    = '0;
    cfg_line_ofs   = '0;
    cfg_cols_used  = USED_RESET;
    cfg_lines_used = USED_RESET;
    foreach (src_written[i]) begin
      src_written[i] = 1'b0;
      src_pix[i]     = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed_cases();
    test_random_traffic();

    // drain and let the pipeline empty out
    wait_idle();
    repeat (4 * PIPE_LAT) @(posedge clk_i);
    if (exp_pixels.size() != 0) begin
      $error("%0d expected results never arrived", exp_pixels.size());
      err_cnt++;
    end

    $display("Covered %0d loads and %0d fetches (%0d out of range), %0d results checked",
             n_loads, n_fetches, n_oor, n_checked);
    $display("across %0d register writes with read-back; %0d errors", n_reg_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
